>>> sv/sobel_pkg.sv
package sobel_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int CFG_WIDTH_BITS = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = 11'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [7:0] MAG_MAX = 8'd255;
   localparam int OUT_DEPTH = 4;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // control that travels with one request down the pipeline
   typedef struct packed {
      logic pixel;
      logic res;
      logic interior;
      logic last;
      logic fwd;
   } stage_type;

endpackage

>>> sv/sobel_edge_magnitude_top.sv
// results pass s1, s2 and the output queue before rsp_tvalid; throughput: one
// request per cycle while req_tready is high, set by the single read-modify-write pass
// over both line stores; a 4-entry output queue holds results while rsp_tready is low
// reset (synchronous, active high) clears counters, window, pipeline and queue and loads
// width 640 and height 480; the line stores are not cleared and need no clearing pass
module sobel_edge_magnitude_top #(
   parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] magnitude
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int DEPTH = sobel_pkg::OUT_DEPTH;
   localparam int QW = $clog2(DEPTH);
   localparam int QCW = $clog2(DEPTH + 1);

   // configuration
   logic [sobel_pkg::CFG_WIDTH_BITS-1:0]  width_ff, width_in;
   logic [sobel_pkg::CFG_HEIGHT_BITS-1:0] height_ff, height_in;
   logic                                  csr_wr;

   // counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [15:0]   in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [15:0]   out_row_ff, out_row_in;
   logic [PW-1:0] pending_ff, pending_in;

   // pipeline
   sobel_pkg::stage_type s1_ff, s1_in, s2_ff, s2_in;
   logic [CW-1:0] s1_addr_ff;
   logic [7:0]    s1_px_ff;
   logic [7:0]    rd_top_ff, rd_mid_ff;
   logic [7:0]    fwd_top_ff, fwd_mid_ff;
   logic [7:0]    upper_store_ff [MAX_WIDTH];
   logic [7:0]    lower_store_ff [MAX_WIDTH];
   logic [7:0]    window_ff [3][3];

   // output queue
   logic [7:0]    q_mag_ff [DEPTH];
   logic          q_last_ff [DEPTH];
   logic [QW-1:0] q_wr_ff, q_rd_ff;
   logic [QCW-1:0] q_count_ff, q_count_in;
   logic          push, pop;

   logic [WW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic          in_acc, is_pixel, res;
   logic          in_col_last, in_row_last, out_col_last, out_row_last, interior;
   logic [PW:0]   pend_inc;
   logic [7:0]    top_val, mid_val;
   logic [9:0]    col_l, col_r, row_t, row_b;
   logic signed [10:0] gx, gy;
   logic [9:0]    ax, ay;
   logic [10:0]   mag_sum;
   logic [7:0]    mag;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (sobel_pkg::reg_index_type'(csr_paddr[2]))
            sobel_pkg::REG_IMAGE_WIDTH:  width_in = csr_pwdata[sobel_pkg::CFG_WIDTH_BITS-1:0];
            sobel_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sobel_pkg::reg_index_type'(csr_paddr[2]))
         sobel_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         sobel_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      eff_h = (height_ff == '0) ? 16'd1 : height_ff;
   end

   // ---------------- request acceptance and counters ----------------
   assign req_tready = (32'(q_count_ff) + 32'(s1_ff.res) + 32'(s2_ff.res)) < 32'(DEPTH);
   assign in_acc = req_tvalid & req_tready;
   assign is_pixel = sobel_pkg::kind_type'(req_tuser) == sobel_pkg::KIND_PIXEL;

   assign in_col_last = (WW'(in_col_ff) + WW'(1)) >= eff_w;
   assign in_row_last = (17'(in_row_ff) + 17'd1) >= 17'(eff_h);
   assign out_col_last = (WW'(out_col_ff) + WW'(1)) >= eff_w;
   assign out_row_last = (17'(out_row_ff) + 17'd1) >= 17'(eff_h);
   assign interior = (out_col_ff != '0) && !out_col_last && (out_row_ff != '0) && !out_row_last;

   assign pend_inc = (PW+1)'(pending_ff) + (PW+1)'(1);
   assign res = is_pixel ? (pend_inc > ((PW+1)'(eff_w) + (PW+1)'(1))) : (pending_ff != '0);

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      s1_in = '0;
      if (in_acc) begin
         if (is_pixel) begin
            if (in_col_last) begin
               in_col_in = '0;
               in_row_in = in_row_last ? 16'd0 : in_row_ff + 16'd1;
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            if (!res) begin
               pending_in = pend_inc[PW-1:0];
            end
         end else if (res) begin
            pending_in = pending_ff - PW'(1);
         end
         if (res) begin
            if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_last ? 16'd0 : out_row_ff + 16'd1;
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
         s1_in.pixel = is_pixel;
         s1_in.res = res;
         s1_in.interior = is_pixel & res & interior;
         s1_in.last = out_col_last & out_row_last;
         // back-to-back hit on the entry still being written back
         s1_in.fwd = is_pixel & s1_ff.pixel & (s1_addr_ff == in_col_ff);
      end
   end

   // ---------------- line stores: read at accept, write back in stage 1 ----------------
   assign top_val = s1_ff.fwd ? fwd_top_ff : rd_top_ff;
   assign mid_val = s1_ff.fwd ? fwd_mid_ff : rd_mid_ff;

   always_ff @(posedge clock) begin
      if (in_acc && is_pixel) begin
         rd_top_ff <= upper_store_ff[in_col_ff];
      end
      if (s1_ff.pixel) begin
         upper_store_ff[s1_addr_ff] <= mid_val;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc && is_pixel) begin
         rd_mid_ff <= lower_store_ff[in_col_ff];
      end
      if (s1_ff.pixel) begin
         lower_store_ff[s1_addr_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_addr_ff <= in_col_ff;
         s1_px_ff <= req_tdata;
      end
      if (s1_ff.pixel) begin
         fwd_top_ff <= mid_val;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else if (s1_ff.pixel) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r][0] <= window_ff[r][1];
            window_ff[r][1] <= window_ff[r][2];
         end
         window_ff[0][2] <= top_val;
         window_ff[1][2] <= mid_val;
         window_ff[2][2] <= s1_px_ff;
      end
   end

   assign s2_in = s1_ff;

   // ---------------- stage 2: gradient magnitude ----------------
   function automatic logic [9:0] weigh(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      weigh = 10'(a) + {1'b0, b, 1'b0} + 10'(c);
   endfunction

   assign col_l = weigh(window_ff[0][0], window_ff[1][0], window_ff[2][0]);
   assign col_r = weigh(window_ff[0][2], window_ff[1][2], window_ff[2][2]);
   assign row_t = weigh(window_ff[0][0], window_ff[0][1], window_ff[0][2]);
   assign row_b = weigh(window_ff[2][0], window_ff[2][1], window_ff[2][2]);
   assign gx = $signed({1'b0, col_r}) - $signed({1'b0, col_l});
   assign gy = $signed({1'b0, row_t}) - $signed({1'b0, row_b});
   assign ax = gx[10] ? 10'(-gx) : gx[9:0];
   assign ay = gy[10] ? 10'(-gy) : gy[9:0];
   assign mag_sum = 11'(ax) + 11'(ay);

   always_comb begin
      if (!s2_ff.interior) begin
         mag = '0;
      end else if (mag_sum > 11'(sobel_pkg::MAG_MAX)) begin
         mag = sobel_pkg::MAG_MAX;
      end else begin
         mag = mag_sum[7:0];
      end
   end

   // ---------------- output queue ----------------
   assign push = s2_ff.res;
   assign rsp_tvalid = q_count_ff != '0;
   assign pop = rsp_tvalid & rsp_tready;
   assign rsp_tdata = q_mag_ff[q_rd_ff];
   assign rsp_tlast = q_last_ff[q_rd_ff];

   always_comb begin
      q_count_in = q_count_ff;
      if (push && !pop) begin
         q_count_in = q_count_ff + QCW'(1);
      end else if (pop && !push) begin
         q_count_in = q_count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mag_ff[q_wr_ff] <= mag;
         q_last_ff[q_wr_ff] <= s2_ff.last;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sobel_pkg::WIDTH_RESET;
         height_ff <= sobel_pkg::HEIGHT_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         q_wr_ff <= '0;
         q_rd_ff <= '0;
         q_count_ff <= '0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         q_count_ff <= q_count_in;
         if (push) begin
            q_wr_ff <= (32'(q_wr_ff) == DEPTH - 1) ? '0 : q_wr_ff + QW'(1);
         end
         if (pop) begin
            q_rd_ff <= (32'(q_rd_ff) == DEPTH - 1) ? '0 : q_rd_ff + QW'(1);
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(q_count_ff) <= DEPTH)
      else $error("output queue over capacity");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && 32'(q_count_ff) == DEPTH) |-> pop)
      else $error("push into full output queue");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= MAX_WIDTH + 1)
      else $error("pending count out of range");

   a_interior_is_result: assert property (@(posedge clock) disable iff (reset)
      s2_ff.interior |-> (s2_ff.res && s2_ff.pixel))
      else $error("interior flag without a pixel result");

   a_fwd_pixel: assert property (@(posedge clock) disable iff (reset)
      s1_ff.fwd |-> ($past(s1_ff.pixel) && s1_ff.pixel))
      else $error("forwarding without a preceding write-back");
`endif

endmodule
